// ===== hw/rtl/fcgi_pkg.sv =====
// shared types and constants for the fastcgi record deframer
`timescale 1ns / 1ps

package fcgi_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_PADDING = 2'd2,
    PH_HALTED  = 2'd3
  } phase_t;

  // result event codes
  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_END     = 2'd1,
    EV_ERROR   = 2'd2
  } event_t;

  // record types of interest
  localparam logic [7:0] T_END_REQUEST = 8'd3;
  localparam logic [7:0] T_STDOUT      = 8'd6;
  localparam logic [7:0] T_STDERR      = 8'd7;
  localparam logic [7:0] T_LIMIT       = 8'd11;

  // header byte positions
  localparam logic [2:0] HB_TYPE   = 3'd1;
  localparam logic [2:0] HB_ID_HI  = 3'd2;
  localparam logic [2:0] HB_ID_LO  = 3'd3;
  localparam logic [2:0] HB_LEN_HI = 3'd4;
  localparam logic [2:0] HB_LEN_LO = 3'd5;
  localparam logic [2:0] HB_PAD    = 3'd6;
  localparam logic [2:0] HB_LAST   = 3'd7;

  // register map
  localparam int          ADDR_W          = 3;
  localparam logic        REG_MAX_REQ_ID  = 1'b0;
  localparam logic [15:0] MAX_REQ_ID_RST  = 16'd255;

  typedef struct packed {
    event_t      kind;
    logic [7:0]  payload;
    logic        from_err;
    logic        last;
    logic [15:0] req_id;
  } result_t;

endpackage

// ===== hw/rtl/fcgi_rec_fsm.sv =====
// record framing state machine: header collection, content and padding counting
`timescale 1ns / 1ps

module fcgi_rec_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  logic [15:0]       max_id,
  output logic              res_valid,
  output fcgi_pkg::result_t res
);

  fcgi_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  hcount_r, hcount_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] clen_r, clen_nxt;
  logic [7:0]  plen_r, plen_nxt;

  logic        last;
  logic        pass;
  logic [7:0]  plen_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fcgi_pkg::PH_HEADER;
      hcount_r <= '0;
      kind_r   <= '0;
      id_r     <= '0;
      clen_r   <= '0;
      plen_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      hcount_r <= hcount_nxt;
      kind_r   <= kind_nxt;
      id_r     <= id_nxt;
      clen_r   <= clen_nxt;
      plen_r   <= plen_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    hcount_nxt   = hcount_r;
    kind_nxt     = kind_r;
    id_nxt       = id_r;
    clen_nxt     = clen_r;
    plen_nxt     = plen_r;
    res_valid    = 1'b0;
    res.kind     = fcgi_pkg::EV_PAYLOAD;
    res.payload  = '0;
    res.from_err = 1'b0;
    res.last     = 1'b0;
    res.req_id   = id_r;
    last         = (clen_r <= 16'd1);
    pass         = (kind_r == fcgi_pkg::T_STDOUT) || (kind_r == fcgi_pkg::T_STDERR);
    plen_dec     = (plen_r != 8'd0) ? plen_r - 8'd1 : 8'd0;

    unique case (phase_r)
      fcgi_pkg::PH_HEADER: begin
        unique case (hcount_r)
          fcgi_pkg::HB_TYPE:   kind_nxt = byte_in;
          fcgi_pkg::HB_ID_HI:  id_nxt   = {byte_in, id_r[7:0]};
          fcgi_pkg::HB_ID_LO:  id_nxt   = {id_r[15:8], byte_in};
          fcgi_pkg::HB_LEN_HI: clen_nxt = {byte_in, clen_r[7:0]};
          fcgi_pkg::HB_LEN_LO: clen_nxt = {clen_r[15:8], byte_in};
          fcgi_pkg::HB_PAD:    plen_nxt = byte_in;
          default: ;
        endcase
        if (hcount_r != fcgi_pkg::HB_LAST) begin
          hcount_nxt = hcount_r + 3'd1;
        end else begin
          hcount_nxt = '0;
          if (id_r > max_id || kind_r >= fcgi_pkg::T_LIMIT) begin
            phase_nxt = fcgi_pkg::PH_HALTED;
            res_valid = 1'b1;
            res.kind  = fcgi_pkg::EV_ERROR;
          end else if (kind_r == fcgi_pkg::T_END_REQUEST) begin
            phase_nxt = fcgi_pkg::PH_HALTED;
            res_valid = 1'b1;
            res.kind  = fcgi_pkg::EV_END;
          end else if (clen_r != 16'd0) begin
            phase_nxt = fcgi_pkg::PH_CONTENT;
          end else begin
            phase_nxt = (plen_r != 8'd0) ? fcgi_pkg::PH_PADDING : fcgi_pkg::PH_HEADER;
          end
        end
      end
      fcgi_pkg::PH_CONTENT: begin
        clen_nxt = (clen_r != 16'd0) ? clen_r - 16'd1 : 16'd0;
        if (last) begin
          phase_nxt = (plen_r != 8'd0) ? fcgi_pkg::PH_PADDING : fcgi_pkg::PH_HEADER;
        end
        if (pass) begin
          res_valid    = 1'b1;
          res.payload  = byte_in;
          res.from_err = (kind_r == fcgi_pkg::T_STDERR);
          res.last     = last;
        end
      end
      fcgi_pkg::PH_PADDING: begin
        plen_nxt = plen_dec;
        if (plen_dec == 8'd0) begin
          phase_nxt = fcgi_pkg::PH_HEADER;
        end
      end
      fcgi_pkg::PH_HALTED: ;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/fastcgi_record_deframer.sv =====
// top level of the fastcgi record deframer: handshakes, register port, result register
`timescale 1ns / 1ps

// Deframes the byte stream sent by a FastCGI application. Each byte is one
// transfer on the in_ channel; STDOUT and STDERR content bytes come out as
// payload results with the last byte of each record flagged, END_REQUEST
// gives an end event and a bad type (11 or above) or a request id above
// max_request_id gives a framing error. After either event input is still
// taken but ignored until reset. Headers, skipped content and padding give
// no result. Throughput is one byte per cycle sustained while results drain:
// a byte sits in an input register, passes through the framing state machine
// and lands in the result register, which presents the result once its byte
// moves on from the input register. Each stage holds one item; while a result
// waits for out_ready one more byte can be taken into the input register, then
// in_ready drops until the result leaves. The only register, max_request_id
// (reset 255), sits at byte address 0 of the APB-style port; write it only
// while the block is idle.

module fastcgi_record_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcgi_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // byte stream in
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_stream_byte,
  // results out
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_event_kind,
  output logic [7:0]                  out_payload_byte,
  output logic                        out_from_error_stream,
  output logic                        out_record_last,
  output logic [15:0]                 out_record_request_id
);

  logic [15:0]       max_id_r;
  logic              in_v_r;
  logic [7:0]        in_byte_r;
  logic              out_v_r;
  fcgi_pkg::result_t out_r;
  logic              adv;
  logic              res_valid;
  fcgi_pkg::result_t res;

  // register port, never inserts wait states (pready tied high)
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_id_r <= fcgi_pkg::MAX_REQ_ID_RST;
    end else if (psel && penable && pwrite && paddr[2] == fcgi_pkg::REG_MAX_REQ_ID) begin
      max_id_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == fcgi_pkg::REG_MAX_REQ_ID) ? {16'd0, max_id_r} : 32'd0;

  // byte moves on when the result register is free or being drained
  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_stream_byte;
    end
  end

  fcgi_rec_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .byte_in   (in_byte_r),
    .max_id    (max_id_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= res_valid;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_v_r;
  assign out_event_kind        = out_r.kind;
  assign out_payload_byte      = out_r.payload;
  assign out_from_error_stream = out_r.from_err;
  assign out_record_last       = out_r.last;
  assign out_record_request_id = out_r.req_id;

endmodule
